[rtl/core/ipl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipl_pkg
// Shared types, constants and small tables of the impact peak localizer.
// ----------------------------------------------------------------------------
package ipl_pkg;

    // Channel count and converter resolution
    localparam int CHANNELS    = 9;
    localparam int SAMPLE_BITS = 12;

    // Sample ports on the scan channel
    localparam int PORT_CH = 9;

    // Fixed widths of the item fields
    localparam int FIELD_W  = 12;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;
    localparam int TARGET_W = 4;
    localparam int GRID_W   = 2;
    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Samples keep only the converter's low bits
    localparam int SAMPLE_KEEP = (SAMPLE_BITS < FIELD_W) ? SAMPLE_BITS : FIELD_W;
    localparam logic [FIELD_W-1:0] SAMPLE_MASK = FIELD_W'((64'd1 << SAMPLE_KEEP) - 64'd1);

    // Register file
    localparam int THR_LO_W = 60;
    localparam int THR_HI_W = 48;
    localparam int THR_LO_CH = 5;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;

    localparam logic [1:0] REG_THR_LO   = 2'd0;
    localparam logic [1:0] REG_THR_HI   = 2'd1;
    localparam logic [1:0] REG_WINDOW   = 2'd2;
    localparam logic [1:0] REG_DEBOUNCE = 2'd3;

    localparam logic [THR_LO_W-1:0] THR_LO_RST   = {THR_LO_W{1'b1}};
    localparam logic [THR_HI_W-1:0] THR_HI_RST   = {THR_HI_W{1'b1}};
    localparam logic [MS_W-1:0]     WINDOW_RST   = 16'd20;
    localparam logic [MS_W-1:0]     DEBOUNCE_RST = 16'd200;

    typedef logic [FIELD_W-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] chan_vec_t;

    // Per-lane control, shared by all lanes
    typedef struct packed {
        logic clear;
        logic track;
    } lane_ctrl_t;

    // Merge result
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        sample_t          peak;
    } winner_t;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_ARMED     = 5'b00010,
        PH_MEASURING = 5'b00100,
        PH_EMIT      = 5'b01000,
        PH_DEBOUNCE  = 5'b10000
    } phase_t;

    // Row of a channel index in the 3-wide grid, from one
    function automatic logic [GRID_W-1:0] grid_row(input logic [TARGET_W-1:0] w);
        logic [GRID_W-1:0] r;
        case (w)
            4'd0, 4'd1, 4'd2: r = 2'd1;
            4'd3, 4'd4, 4'd5: r = 2'd2;
            default:          r = 2'd3;
        endcase
        return r;
    endfunction

    // Column of a channel index in the 3-wide grid, from one
    function automatic logic [GRID_W-1:0] grid_col(input logic [TARGET_W-1:0] w);
        logic [GRID_W-1:0] c;
        case (w)
            4'd0, 4'd3, 4'd6: c = 2'd1;
            4'd1, 4'd4, 4'd7: c = 2'd2;
            default:          c = 2'd3;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/ipl_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipl_lane
// One sensor channel: threshold compare and peak hold register.
// ----------------------------------------------------------------------------
module ipl_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  ipl_pkg::lane_ctrl_t ctrl,
    input  ipl_pkg::sample_t    sample,
    input  ipl_pkg::sample_t    threshold,
    output logic                hit,
    output ipl_pkg::sample_t    peak
);
    import ipl_pkg::*;

    sample_t s_masked;
    sample_t peak_reg;
    sample_t peak_next;

    assign s_masked = sample & SAMPLE_MASK;
    assign hit      = (s_masked >= threshold);
    assign peak     = peak_reg;

    // Clear on trigger, raise while tracking
    always_comb begin
        peak_next = peak_reg;
        if (ctrl.clear) begin
            peak_next = '0;
        end else if (ctrl.track && (s_masked > peak_reg)) begin
            peak_next = s_masked;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else begin
            peak_reg <= peak_next;
        end
    end

endmodule

[rtl/core/ipl_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipl_merge
// Picks the loudest lane; the lowest index wins a tie.
// ----------------------------------------------------------------------------
module ipl_merge (
    input  ipl_pkg::chan_vec_t peaks,
    output ipl_pkg::winner_t   win
);
    import ipl_pkg::*;

    // Strictly greater replaces, so equal peaks keep the lower index
    always_comb begin
        win.idx  = '0;
        win.peak = peaks[0];
        for (int i = 1; i < CHANNELS; i++) begin
            if (peaks[i] > win.peak) begin
                win.idx  = IDX_W'(i);
                win.peak = peaks[i];
            end
        end
    end

endmodule

[rtl/core/impact_peak_localizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impact_peak_localizer
// Nine-channel impact detector: trigger, windowed peak hold, loudest-channel
// report and debounce, with an APB-style register port.
// ----------------------------------------------------------------------------
// Throughput: one scan item per cycle; the input stalls only while a report
// sits in the output register and is not taken.
// Report: registered at the edge that accepts the scan following the one that
// closes the peak window.
// Reset: synchronous, active low; phase returns to idle, peaks and time marks
// clear, registers take their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module impact_peak_localizer (
    input  logic        aclk,
    input  logic        aresetn,
    // Scan items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_sample_one,
    input  logic [11:0] s_sample_two,
    input  logic [11:0] s_sample_three,
    input  logic [11:0] s_sample_four,
    input  logic [11:0] s_sample_five,
    input  logic [11:0] s_sample_six,
    input  logic [11:0] s_sample_seven,
    input  logic [11:0] s_sample_eight,
    input  logic [11:0] s_sample_nine,
    input  logic [31:0] s_now_ms,
    // Report items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_target_number,
    output logic [1:0]  m_grid_row,
    output logic [1:0]  m_grid_column,
    output logic [11:0] m_intensity,
    output logic [31:0] m_event_time_ms,
    // Register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ipl_pkg::ADDR_W-1:0]  paddr,
    input  logic [ipl_pkg::DATA_W-1:0]  pwdata,
    output logic [ipl_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import ipl_pkg::*;

    // Registers
    logic [THR_LO_W-1:0] thr_lo_reg;
    logic [THR_HI_W-1:0] thr_hi_reg;
    logic [MS_W-1:0]     window_reg;
    logic [MS_W-1:0]     debounce_reg;
    logic [1:0]          reg_idx;
    logic                wr_en;

    phase_t             phase_reg, phase_next;
    logic [TIME_W-1:0]  win_start_reg;
    logic [TIME_W-1:0]  deb_start_reg;

    logic               m_valid_reg;
    logic [TARGET_W-1:0] m_target_reg;
    logic [GRID_W-1:0]  m_row_reg;
    logic [GRID_W-1:0]  m_col_reg;
    sample_t            m_int_reg;
    logic [TIME_W-1:0]  m_time_reg;

    sample_t            samples   [PORT_CH];
    sample_t            thr       [PORT_CH];
    logic [CHANNELS-1:0] hit_vec;
    chan_vec_t          peaks;
    winner_t            win;
    lane_ctrl_t         lane_ctrl;
    logic [TARGET_W-1:0] win_idx;

    logic in_accept;
    logic is_idle;
    logic trig;
    logic win_done;
    logic deb_done;
    logic emit_fire;

    // Register port: writes at the access phase, reads decode the index
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_lo_reg   <= THR_LO_RST;
            thr_hi_reg   <= THR_HI_RST;
            window_reg   <= WINDOW_RST;
            debounce_reg <= DEBOUNCE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_THR_LO:   thr_lo_reg   <= pwdata[THR_LO_W-1:0];
                REG_THR_HI:   thr_hi_reg   <= pwdata[THR_HI_W-1:0];
                REG_WINDOW:   window_reg   <= pwdata[MS_W-1:0];
                REG_DEBOUNCE: debounce_reg <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THR_LO:   prdata = DATA_W'(thr_lo_reg);
            REG_THR_HI:   prdata = DATA_W'(thr_hi_reg);
            REG_WINDOW:   prdata = DATA_W'(window_reg);
            REG_DEBOUNCE: prdata = DATA_W'(debounce_reg);
            default:      prdata = '0;
        endcase
    end

    // Input gathering
    assign samples[0] = s_sample_one;
    assign samples[1] = s_sample_two;
    assign samples[2] = s_sample_three;
    assign samples[3] = s_sample_four;
    assign samples[4] = s_sample_five;
    assign samples[5] = s_sample_six;
    assign samples[6] = s_sample_seven;
    assign samples[7] = s_sample_eight;
    assign samples[8] = s_sample_nine;

    for (genvar i = 0; i < PORT_CH; i++) begin : g_thr
        if (i < THR_LO_CH) begin : g_lo
            assign thr[i] = thr_lo_reg[FIELD_W*i +: FIELD_W];
        end else begin : g_hi
            assign thr[i] = thr_hi_reg[FIELD_W*(i-THR_LO_CH) +: FIELD_W];
        end
    end

    // Handshake and phase decode
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;
    assign is_idle   = !(phase_reg == PH_ARMED || phase_reg == PH_MEASURING ||
                         phase_reg == PH_EMIT  || phase_reg == PH_DEBOUNCE);
    assign trig      = |hit_vec;
    assign win_done  = (s_now_ms - win_start_reg) >= TIME_W'(window_reg);
    assign deb_done  = (s_now_ms - deb_start_reg) >= TIME_W'(debounce_reg);
    assign emit_fire = in_accept && (phase_reg == PH_EMIT);

    assign lane_ctrl.clear = in_accept && is_idle && trig;
    assign lane_ctrl.track = in_accept &&
                             (phase_reg == PH_ARMED || phase_reg == PH_MEASURING);

    // Lanes
    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        ipl_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (lane_ctrl),
            .sample    (samples[i]),
            .threshold (thr[i]),
            .hit       (hit_vec[i]),
            .peak      (peaks[i])
        );
    end

    // Merge
    ipl_merge u_merge (
        .peaks (peaks),
        .win   (win)
    );

    assign win_idx = TARGET_W'(win.idx);

    // Phase sequencing
    always_comb begin
        phase_next = phase_reg;
        if (in_accept) begin
            case (phase_reg)
                PH_ARMED:     phase_next = PH_MEASURING;
                PH_MEASURING: phase_next = win_done ? PH_EMIT : PH_MEASURING;
                PH_EMIT:      phase_next = PH_DEBOUNCE;
                PH_DEBOUNCE:  phase_next = deb_done ? PH_IDLE : PH_DEBOUNCE;
                default:      phase_next = trig ? PH_ARMED : PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            win_start_reg <= '0;
            deb_start_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            if (lane_ctrl.clear) begin
                win_start_reg <= s_now_ms;
            end
            if (emit_fire) begin
                deb_start_reg <= s_now_ms;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_target_reg <= win_idx + TARGET_W'(1);
            m_row_reg    <= grid_row(win_idx);
            m_col_reg    <= grid_col(win_idx);
            m_int_reg    <= win.peak;
            m_time_reg   <= s_now_ms;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_target_number = m_target_reg;
    assign m_grid_row      = m_row_reg;
    assign m_grid_column   = m_col_reg;
    assign m_intensity     = m_int_reg;
    assign m_event_time_ms = m_time_reg;

    // Checks
    a_report_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(emit_fire))
        else $error("report raised without an emit scan");

    a_emit_to_debounce: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> (m_valid_reg && phase_reg == PH_DEBOUNCE))
        else $error("emit scan did not report and enter debounce");

    a_idle_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && is_idle && !trig) |=> (phase_reg == PH_IDLE))
        else $error("left idle without a trigger");

    a_report_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(m_time_reg)))
        else $error("stalled report changed");

endmodule
